// File: sv/ccv_pkg.sv
// ccv_pkg: shared widths, symbol codes and limits of the column consensus voter
// used by column_consensus_voter_unit and ccv_ram users; depends on nothing else
`default_nettype none

package ccv_pkg;

    // field widths
    localparam int SYM_W = 8;
    localparam int CNT_W = 11;
    localparam int PCT_W = 7;
    localparam int NUM_SYMS = 1 << SYM_W;

    // row limit and count saturation point
    localparam int MAX_ROWS = 1024;
    localparam int CNT_CAP_INT = (MAX_ROWS < 2047) ? MAX_ROWS : 2047;
    localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CNT_CAP_INT);

    // symbol codes
    localparam logic [SYM_W-1:0] GAP_SYM     = 8'd45;   // '-'
    localparam logic [SYM_W-1:0] FILL_UPPER  = 8'd78;   // 'N'
    localparam logic [SYM_W-1:0] FILL_LOWER  = 8'd110;  // 'n'
    localparam logic [SYM_W-1:0] LOWER_BOUND = 8'd65;   // 'A'
    localparam logic [SYM_W-1:0] BEST_RESET  = 8'd32;   // space

    // agreement threshold
    localparam logic [PCT_W-1:0] AGREE_RESET = 7'd60;
    localparam int PROD_W = CNT_W + PCT_W;
    localparam logic [PCT_W-1:0] FULL_PERCENT = 7'd100;

    // result queue
    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);
    localparam int PEND_W = $clog2(FIFO_DEPTH + 3);

endpackage

`default_nettype wire

// File: sv/ccv_ram.sv
// ccv_ram: generic single-write, single-read ram with registered read data
// read-first on an address collision; no dependencies
`default_nettype none

module ccv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: sv/column_consensus_voter_unit.sv
// column_consensus_voter_unit: majority-vote consensus over alignment columns
// depends on ccv_pkg and ccv_ram
`default_nettype none

// Usage
// Input channel (in_valid/in_ready): one row symbol per transfer, with last_row
// closing the column and group_start opening a new group (a partial column is
// dropped). Output channel (out_valid/out_ready): one consensus/is_fill
// result per column, via the update stage, the compare stage and the result queue.
// Config channel (cfg_valid/cfg_ready): writes agree_percent, always ready;
// write it only while no item is in flight.
// Throughput: one row per cycle while not stalled. Per-symbol counts live in
// a 256-entry ram with a registered read; the update stage forwards its own
// write to the next row. Results pass a compare stage and a three-entry queue;
// in_ready falls only while four results are pending since the receiver stalls.
// Reset: counts read as zero through per-symbol valid bits, so the block is
// ready straight out of reset, with agree_percent at 60.
module column_consensus_voter_unit
    import ccv_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [SYM_W-1:0] symbol,
    input  wire logic             last_row,
    input  wire logic             group_start,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [SYM_W-1:0] consensus,
    output logic                  is_fill,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [PCT_W-1:0] agree_percent
);

    logic in_fire;
    logic pop;
    logic push;
    logic s2_move;
    logic [PEND_W-1:0] pending;

    // config register
    logic [PCT_W-1:0] agree_reg;

    // update stage
    logic             s1_valid_reg;
    logic [SYM_W-1:0] s1_sym_reg;
    logic             s1_last_reg;
    logic             s1_gstart_reg;
    logic [CNT_W-1:0] ram_rdata;

    // write-back forwarding
    logic             wr_valid_reg;
    logic             wr_clr_reg;
    logic [SYM_W-1:0] wr_sym_reg;
    logic [CNT_W-1:0] wr_cnt_reg;
    logic             fwd_hit;

    // column state
    logic [NUM_SYMS-1:0] cnt_valid_reg, cnt_valid_next;
    logic [CNT_W-1:0]    row_total_reg, row_total_next;
    logic [SYM_W-1:0]    best_sym_reg, best_sym_next;
    logic [CNT_W-1:0]    best_cnt_reg, best_cnt_next;
    logic                fill_lower_reg, fill_lower_next;

    logic [CNT_W-1:0] cnt_base;
    logic [CNT_W-1:0] cnt_upd;
    logic [CNT_W-1:0] rt_base;
    logic [CNT_W-1:0] rt_upd;
    logic [CNT_W-1:0] bc_base;
    logic [SYM_W-1:0] bs_base;
    logic [CNT_W-1:0] bc_upd;
    logic [SYM_W-1:0] bs_upd;

    // compare stage
    logic             s2_valid_reg;
    logic [SYM_W-1:0] s2_sym_reg;
    logic [CNT_W-1:0] s2_cnt_reg;
    logic [CNT_W-1:0] s2_rt_reg;
    logic             s2_fill_lower_reg;
    logic [PROD_W-1:0] lhs;
    logic [PROD_W-1:0] rhs;
    logic             accept_sym;
    logic [SYM_W-1:0] res_sym;
    logic             res_fill;

    // result queue
    logic [SYM_W-1:0]   q_sym_reg [FIFO_DEPTH];
    logic               q_fill_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] q_wr_reg;
    logic [FIFO_AW-1:0] q_rd_reg;
    logic [FIFO_CW-1:0] q_cnt_reg;

    // handshakes
    assign cfg_ready = 1'b1;
    assign pending   = PEND_W'(s1_valid_reg & s1_last_reg) + PEND_W'(s2_valid_reg)
                     + PEND_W'(q_cnt_reg);
    assign in_ready  = (pending <= PEND_W'(FIFO_DEPTH));
    assign in_fire   = in_valid & in_ready;
    assign out_valid = (q_cnt_reg != '0);
    assign pop       = out_valid & out_ready;
    assign s2_move   = s2_valid_reg & ((q_cnt_reg != FIFO_CW'(FIFO_DEPTH)) | pop);
    assign push      = s2_move;
    assign consensus = q_sym_reg[q_rd_reg];
    assign is_fill   = q_fill_reg[q_rd_reg];

    // per-symbol count memory
    ccv_ram #(
        .WIDTH(CNT_W),
        .DEPTH(NUM_SYMS)
    ) u_count_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_sym_reg),
        .wdata (cnt_upd),
        .re    (in_fire),
        .raddr (symbol),
        .rdata (ram_rdata)
    );

    // count read with forwarding of the previous write
    assign fwd_hit = wr_valid_reg & ~wr_clr_reg & (wr_sym_reg == s1_sym_reg);

    always_comb
    begin
        priority if (s1_gstart_reg)
        begin
            cnt_base = '0;
        end
        else if (fwd_hit)
        begin
            cnt_base = wr_cnt_reg;
        end
        else if (cnt_valid_reg[s1_sym_reg])
        begin
            cnt_base = ram_rdata;
        end
        else
        begin
            cnt_base = '0;
        end
    end

    // saturating count and row total, running best
    always_comb
    begin
        cnt_upd = (cnt_base < CNT_CAP) ? cnt_base + CNT_W'(1) : cnt_base;
        rt_base = s1_gstart_reg ? '0 : row_total_reg;
        rt_upd  = (rt_base < CNT_CAP) ? rt_base + CNT_W'(1) : rt_base;
        bc_base = s1_gstart_reg ? '0 : best_cnt_reg;
        bs_base = s1_gstart_reg ? BEST_RESET : best_sym_reg;
        if (cnt_upd > bc_base)
        begin
            bc_upd = cnt_upd;
            bs_upd = s1_sym_reg;
        end
        else
        begin
            bc_upd = bc_base;
            bs_upd = bs_base;
        end
    end

    // column state next values
    always_comb
    begin
        cnt_valid_next  = cnt_valid_reg;
        row_total_next  = row_total_reg;
        best_sym_next   = best_sym_reg;
        best_cnt_next   = best_cnt_reg;
        fill_lower_next = fill_lower_reg;
        if (s1_valid_reg)
        begin
            if (s1_gstart_reg)
            begin
                fill_lower_next = (s1_sym_reg < LOWER_BOUND);
            end
            if (s1_last_reg)
            begin
                cnt_valid_next = '0;
                row_total_next = '0;
                best_sym_next  = BEST_RESET;
                best_cnt_next  = '0;
            end
            else
            begin
                if (s1_gstart_reg)
                begin
                    cnt_valid_next = '0;
                end
                cnt_valid_next[s1_sym_reg] = 1'b1;
                row_total_next = rt_upd;
                best_sym_next  = bs_upd;
                best_cnt_next  = bc_upd;
            end
        end
    end

    // control and column state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            agree_reg      <= AGREE_RESET;
            s1_valid_reg   <= 1'b0;
            wr_valid_reg   <= 1'b0;
            wr_clr_reg     <= 1'b0;
            cnt_valid_reg  <= '0;
            row_total_reg  <= '0;
            best_sym_reg   <= BEST_RESET;
            best_cnt_reg   <= '0;
            fill_lower_reg <= 1'b0;
            s2_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid & cfg_ready)
            begin
                agree_reg <= agree_percent;
            end
            s1_valid_reg   <= in_fire;
            wr_valid_reg   <= s1_valid_reg;
            wr_clr_reg     <= s1_last_reg;
            cnt_valid_reg  <= cnt_valid_next;
            row_total_reg  <= row_total_next;
            best_sym_reg   <= best_sym_next;
            best_cnt_reg   <= best_cnt_next;
            fill_lower_reg <= fill_lower_next;
            if (s1_valid_reg & s1_last_reg)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_move)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers of the pipeline
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_sym_reg    <= symbol;
            s1_last_reg   <= last_row;
            s1_gstart_reg <= group_start;
        end
        wr_sym_reg <= s1_sym_reg;
        wr_cnt_reg <= cnt_upd;
        if (s1_valid_reg & s1_last_reg)
        begin
            s2_sym_reg        <= bs_upd;
            s2_cnt_reg        <= bc_upd;
            s2_rt_reg         <= rt_upd;
            s2_fill_lower_reg <= s1_gstart_reg ? (s1_sym_reg < LOWER_BOUND) : fill_lower_reg;
        end
    end

    // agreement test: best_count * 100 >= row_total * agree_percent, best not a gap
    always_comb
    begin
        lhs        = PROD_W'(s2_cnt_reg) * PROD_W'(FULL_PERCENT);
        rhs        = PROD_W'(s2_rt_reg) * PROD_W'(agree_reg);
        accept_sym = (s2_sym_reg != GAP_SYM) && (lhs >= rhs);
        res_sym    = accept_sym ? s2_sym_reg : (s2_fill_lower_reg ? FILL_LOWER : FILL_UPPER);
        res_fill   = ~accept_sym;
    end

    // result queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                q_wr_reg <= (q_wr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : q_wr_reg + FIFO_AW'(1);
            end
            if (pop)
            begin
                q_rd_reg <= (q_rd_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : q_rd_reg + FIFO_AW'(1);
            end
            unique case ({push, pop})
                2'b10:   q_cnt_reg <= q_cnt_reg + FIFO_CW'(1);
                2'b01:   q_cnt_reg <= q_cnt_reg - FIFO_CW'(1);
                default: q_cnt_reg <= q_cnt_reg;
            endcase
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_sym_reg[q_wr_reg]  <= res_sym;
            q_fill_reg[q_wr_reg] <= res_fill;
        end
    end

`ifndef SYNTHESIS
    // a closing row always finds the compare stage free or draining
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_last_reg) |-> (!s2_valid_reg || s2_move))
        else $error("column result would overwrite a pending compare");

    // the result queue never overflows
    assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overflow");

    // forwarded count is only used right after a write of the same symbol
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && fwd_hit) |-> ($past(s1_valid_reg) && !$past(s1_last_reg)))
        else $error("forwarding without a matching write");

    // pending results stay within the buffering
    assert property (@(posedge clk) disable iff (!rst_n)
        pending <= PEND_W'(FIFO_DEPTH + 1))
        else $error("too many results in flight");
`endif

endmodule

`default_nettype wire
